// File: rtl/lsmt_pkg.sv
// Shared constants, table word layouts and controller/datapath command types
// for the linear sieve Mobius/totient unit. No dependencies.
package lsmt_pkg;

   localparam int MAX_LIMIT   = 4096;
   localparam int PRIME_SLOTS = 1024;

   localparam int IDX_W  = $clog2(MAX_LIMIT + 1);
   localparam int TBL_D  = MAX_LIMIT + 1;
   localparam int PC_W   = $clog2(PRIME_SLOTS + 1);
   localparam int PA_W   = $clog2(PRIME_SLOTS);
   localparam int PROD_W = 2 * IDX_W;
   localparam int MU_W   = 2;
   localparam int PHI_W  = 12;
   localparam int MSUM_W = 14;
   localparam int TSUM_W = 24;

   localparam logic [IDX_W-1:0] LIMIT_MAX   = IDX_W'(MAX_LIMIT);
   localparam logic [IDX_W-1:0] LIMIT_RESET = IDX_W'(MAX_LIMIT);
   localparam logic [PC_W-1:0]  SLOTS_FULL  = PC_W'(PRIME_SLOTS);

   localparam logic ACT_BUILD = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   localparam logic [MU_W-1:0] MU_ZERO = 2'b00;
   localparam logic [MU_W-1:0] MU_POS  = 2'b01;
   localparam logic [MU_W-1:0] MU_NEG  = 2'b11;

   typedef struct packed {
      logic             comp;
      logic [MU_W-1:0]  mu;
      logic [PHI_W-1:0] phi;
      logic [IDX_W-1:0] lpf;
   } sieve_word_type;

   typedef struct packed {
      logic [MSUM_W-1:0] msum;
      logic [TSUM_W-1:0] tsum;
   } pfx_word_type;

   typedef struct packed {
      logic query;
      logic bld_start;
      logic clr_wr;
      logic rd_i;
      logic chk;
      logic mul;
      logic mark;
      logic wr_m;
      logic next_i;
      logic pfx_init;
      logic p_rd;
      logic p_acc;
      logic done;
   } ctl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic i_over;
      logic j_ok;
      logic prod_over;
      logic div;
      logic k_over;
   } dp_status_type;

endpackage

// File: rtl/linear_sieve_mobius_totient_unit.sv
// Top level of the linear sieve Mobius/totient unit.
// Depends on lsmt_pkg, lsmt_ctrl, lsmt_dp (which holds the lsmt_ram tables).
//
//   channel   ports                                   handshake
//   request   req_action, req_index                   start & !busy
//   result    rsp_mobius .. rsp_totient_sum, status   rsp_strobe, one cycle
//   config    csr_wr_data                             csr_wr_en
//
// Query: one word per cycle while not busy; table read and result stage registered.
// Build: busy through the clear, sieve and prefix passes, all on the one read and
//   one write port of the sieve table RAM; its result word passes the result stage
//   registers after the sequence ends.
// After reset every query returns zero until the first build; no clearing pass.
// Results cannot be stalled; results come back in acceptance order.
module linear_sieve_mobius_totient_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_action,
   input  logic [lsmt_pkg::IDX_W-1:0]        req_index,
   input  logic                              csr_wr_en,
   input  logic [lsmt_pkg::IDX_W-1:0]        csr_wr_data,
   output logic                              rsp_strobe,
   output logic signed [lsmt_pkg::MU_W-1:0]  rsp_mobius,
   output logic [lsmt_pkg::PHI_W-1:0]        rsp_totient,
   output logic signed [lsmt_pkg::MSUM_W-1:0] rsp_mobius_sum,
   output logic [lsmt_pkg::TSUM_W-1:0]       rsp_totient_sum,
   output logic                              rsp_status
);
   import lsmt_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type sts;

   lsmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .sts        (sts),
      .busy       (busy),
      .cmd        (cmd)
   );

   lsmt_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_index       (req_index),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_strobe      (rsp_strobe),
      .rsp_mobius      (rsp_mobius),
      .rsp_totient     (rsp_totient),
      .rsp_mobius_sum  (rsp_mobius_sum),
      .rsp_totient_sum (rsp_totient_sum),
      .rsp_status      (rsp_status)
   );

endmodule

// File: rtl/lsmt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsmt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: rtl/lsmt_ctrl.sv
// Build sequencer and query issue for the sieve unit.
// Depends on lsmt_pkg for command and status types.
module lsmt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_action,
   input  lsmt_pkg::dp_status_type sts,
   output logic                  busy,
   output lsmt_pkg::ctl_cmd_type cmd
);
   import lsmt_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_RDI,
      ST_CHK,
      ST_RDP,
      ST_MUL,
      ST_MARK,
      ST_WR,
      ST_PRD,
      ST_PACC,
      ST_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_action == ACT_BUILD) begin
                  cmd.bld_start = 1'b1;
                  state_in      = ST_CLEAR;
               end else begin
                  cmd.query = 1'b1;
               end
            end
         end
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_RDI;
            end
         end
         ST_RDI: begin
            if (sts.i_over) begin
               cmd.pfx_init = 1'b1;
               state_in     = ST_PRD;
            end else begin
               cmd.rd_i = 1'b1;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            cmd.chk  = 1'b1;
            state_in = ST_RDP;
         end
         ST_RDP: begin
            if (sts.j_ok) begin
               state_in = ST_MUL;
            end else begin
               cmd.next_i = 1'b1;
               state_in   = ST_RDI;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_MARK;
         end
         ST_MARK: begin
            if (sts.prod_over) begin
               cmd.next_i = 1'b1;
               state_in   = ST_RDI;
            end else begin
               cmd.mark = 1'b1;
               state_in = ST_WR;
            end
         end
         ST_WR: begin
            cmd.wr_m = 1'b1;
            if (sts.div) begin
               cmd.next_i = 1'b1;
               state_in   = ST_RDI;
            end else begin
               state_in = ST_RDP;
            end
         end
         ST_PRD: begin
            if (sts.k_over) begin
               state_in = ST_DONE;
            end else begin
               cmd.p_rd = 1'b1;
               state_in = ST_PACC;
            end
         end
         ST_PACC: begin
            cmd.p_acc = 1'b1;
            state_in  = ST_PRD;
         end
         ST_DONE: begin
            cmd.done = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/lsmt_dp.sv
// Datapath: limit register, sieve counters, multipliers, table RAMs and result stage.
// Depends on lsmt_pkg and lsmt_ram.
module lsmt_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  lsmt_pkg::ctl_cmd_type          cmd,
   output lsmt_pkg::dp_status_type        sts,
   input  logic [lsmt_pkg::IDX_W-1:0]     req_index,
   input  logic                           csr_wr_en,
   input  logic [lsmt_pkg::IDX_W-1:0]     csr_wr_data,
   output logic                           rsp_strobe,
   output logic signed [lsmt_pkg::MU_W-1:0]   rsp_mobius,
   output logic [lsmt_pkg::PHI_W-1:0]     rsp_totient,
   output logic signed [lsmt_pkg::MSUM_W-1:0] rsp_mobius_sum,
   output logic [lsmt_pkg::TSUM_W-1:0]    rsp_totient_sum,
   output logic                           rsp_status
);
   import lsmt_pkg::*;

   logic [IDX_W-1:0]  limit_ff;
   logic [IDX_W-1:0]  eff_lim;
   logic [IDX_W-1:0]  lim_ff;
   logic [IDX_W-1:0]  built_lim_ff;
   logic [IDX_W-1:0]  i_ff;
   logic [IDX_W-1:0]  cnt_ff;
   logic [PC_W-1:0]   j_ff;
   logic [PC_W-1:0]   pc_ff;
   logic [MU_W-1:0]   mu_i_ff;
   logic [PHI_W-1:0]  phi_i_ff;
   logic [IDX_W-1:0]  lpf_i_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [IDX_W-1:0]  p_ff;
   logic              div_ff;
   logic [IDX_W-1:0]  m_ff;
   logic [MU_W-1:0]   mu_m_ff;
   logic [PHI_W-1:0]  phi_m_ff;
   logic [MSUM_W-1:0] msum_ff;
   logic [TSUM_W-1:0] tsum_ff;
   logic [MSUM_W-1:0] msum_in;
   logic [TSUM_W-1:0] tsum_in;
   logic              q1_vld_ff;
   logic              q1_status_ff;
   logic              q1_zero_ff;
   logic              q_status_in;

   logic [IDX_W-1:0]  fac;
   logic [PHI_W+IDX_W-1:0] phi_prod;
   logic [PROD_W-1:0] prod_in;
   logic              new_prime;

   logic              sv_wr_en;
   logic [IDX_W-1:0]  sv_wr_addr;
   sieve_word_type    sv_wr_data;
   logic [IDX_W-1:0]  sv_rd_addr;
   sieve_word_type    sv_q;

   logic              pr_wr_en;
   logic [IDX_W-1:0]  pr_q;

   pfx_word_type      px_wr_data;
   pfx_word_type      px_q;

   assign eff_lim = (limit_ff > LIMIT_MAX) ? LIMIT_MAX : limit_ff;

   assign sts.clr_last  = (cnt_ff == lim_ff);
   assign sts.k_over    = (cnt_ff > lim_ff);
   assign sts.i_over    = (i_ff > lim_ff);
   assign sts.j_ok      = (j_ff < pc_ff);
   assign sts.prod_over = (prod_ff > PROD_W'(lim_ff));
   assign sts.div       = div_ff;

   assign new_prime = cmd.chk && !sv_q.comp;
   assign pr_wr_en  = new_prime && (pc_ff < SLOTS_FULL);
   assign prod_in   = PROD_W'(pr_q) * PROD_W'(i_ff);
   assign fac       = div_ff ? p_ff : p_ff - 1'b1;
   assign phi_prod  = (PHI_W + IDX_W)'(phi_i_ff) * (PHI_W + IDX_W)'(fac);
   assign msum_in   = msum_ff + {{(MSUM_W - MU_W){sv_q.mu[MU_W-1]}}, sv_q.mu};
   assign tsum_in   = tsum_ff + TSUM_W'(sv_q.phi);
   assign q_status_in = (req_index > eff_lim);

   always_comb begin
      sv_wr_en   = 1'b0;
      sv_wr_addr = cnt_ff;
      sv_wr_data = '0;
      if (cmd.clr_wr) begin
         sv_wr_en = 1'b1;
         if (cnt_ff == IDX_W'(1)) begin
            sv_wr_data.mu  = MU_POS;
            sv_wr_data.phi = PHI_W'(1);
            sv_wr_data.lpf = IDX_W'(1);
         end
      end else if (new_prime) begin
         sv_wr_en       = 1'b1;
         sv_wr_addr     = i_ff;
         sv_wr_data.mu  = MU_NEG;
         sv_wr_data.phi = PHI_W'(i_ff - 1'b1);
         sv_wr_data.lpf = i_ff;
      end else if (cmd.wr_m) begin
         sv_wr_en        = 1'b1;
         sv_wr_addr      = m_ff;
         sv_wr_data.comp = 1'b1;
         sv_wr_data.mu   = mu_m_ff;
         sv_wr_data.phi  = phi_m_ff;
         sv_wr_data.lpf  = p_ff;
      end
   end

   always_comb begin
      if (cmd.rd_i) begin
         sv_rd_addr = i_ff;
      end else if (cmd.p_rd) begin
         sv_rd_addr = cnt_ff;
      end else begin
         sv_rd_addr = req_index;
      end
   end

   assign px_wr_data.msum = msum_in;
   assign px_wr_data.tsum = tsum_in;

   lsmt_ram #(
      .WIDTH ($bits(sieve_word_type)),
      .DEPTH (TBL_D)
   ) u_sieve_ram (
      .clock   (clock),
      .wr_en   (sv_wr_en),
      .wr_addr (sv_wr_addr),
      .wr_data (sv_wr_data),
      .rd_addr (sv_rd_addr),
      .rd_data (sv_q)
   );

   lsmt_ram #(
      .WIDTH (IDX_W),
      .DEPTH (PRIME_SLOTS)
   ) u_prime_ram (
      .clock   (clock),
      .wr_en   (pr_wr_en),
      .wr_addr (pc_ff[PA_W-1:0]),
      .wr_data (i_ff),
      .rd_addr (j_ff[PA_W-1:0]),
      .rd_data (pr_q)
   );

   lsmt_ram #(
      .WIDTH ($bits(pfx_word_type)),
      .DEPTH (TBL_D)
   ) u_pfx_ram (
      .clock   (clock),
      .wr_en   (cmd.p_acc),
      .wr_addr (cnt_ff),
      .wr_data (px_wr_data),
      .rd_addr (req_index),
      .rd_data (px_q)
   );

   // sieve working registers
   always_ff @(posedge clock) begin
      if (cmd.bld_start) begin
         lim_ff <= eff_lim;
         cnt_ff <= '0;
         i_ff   <= IDX_W'(2);
         pc_ff  <= '0;
      end
      if (cmd.clr_wr || cmd.p_acc) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.pfx_init) begin
         cnt_ff  <= IDX_W'(1);
         msum_ff <= '0;
         tsum_ff <= '0;
      end
      if (cmd.p_acc) begin
         msum_ff <= msum_in;
         tsum_ff <= tsum_in;
      end
      if (cmd.chk) begin
         j_ff <= '0;
         if (sv_q.comp) begin
            mu_i_ff  <= sv_q.mu;
            phi_i_ff <= sv_q.phi;
            lpf_i_ff <= sv_q.lpf;
         end else begin
            mu_i_ff  <= MU_NEG;
            phi_i_ff <= PHI_W'(i_ff - 1'b1);
            lpf_i_ff <= i_ff;
         end
      end
      if (pr_wr_en) begin
         pc_ff <= pc_ff + 1'b1;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
         p_ff    <= pr_q;
         div_ff  <= (pr_q == lpf_i_ff);
      end
      if (cmd.mark) begin
         m_ff     <= prod_ff[IDX_W-1:0];
         phi_m_ff <= phi_prod[PHI_W-1:0];
         mu_m_ff  <= div_ff ? MU_ZERO : MU_W'(MU_ZERO - mu_i_ff);
      end
      if (cmd.wr_m) begin
         j_ff <= j_ff + 1'b1;
      end
      if (cmd.next_i) begin
         i_ff <= i_ff + 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         built_lim_ff <= '0;
         q1_vld_ff    <= 1'b0;
         rsp_strobe   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (cmd.done) begin
            built_lim_ff <= lim_ff;
         end
         q1_vld_ff  <= cmd.query || cmd.done;
         rsp_strobe <= q1_vld_ff;
      end
   end

   // result stage
   always_ff @(posedge clock) begin
      if (cmd.done) begin
         q1_status_ff <= STATUS_OK;
         q1_zero_ff   <= 1'b1;
      end else begin
         q1_status_ff <= q_status_in ? STATUS_RANGE : STATUS_OK;
         q1_zero_ff   <= q_status_in || (req_index == '0) || (req_index > built_lim_ff);
      end
      rsp_status <= q1_status_ff;
      if (q1_zero_ff) begin
         rsp_mobius      <= '0;
         rsp_totient     <= '0;
         rsp_mobius_sum  <= '0;
         rsp_totient_sum <= '0;
      end else begin
         rsp_mobius      <= sv_q.mu;
         rsp_totient     <= sv_q.phi;
         rsp_mobius_sum  <= px_q.msum;
         rsp_totient_sum <= px_q.tsum;
      end
   end

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == STATUS_RANGE |-> rsp_totient == '0 && rsp_mobius == '0
         && rsp_mobius_sum == '0 && rsp_totient_sum == '0)
      else $error("out-of-range word carries table data");

   a_pc_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.chk |-> pc_ff <= SLOTS_FULL)
      else $error("prime count past slot count");

   a_mark_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_m |-> m_ff <= lim_ff && m_ff > IDX_W'(1))
      else $error("mark outside sieve range");

   a_done_word: assert property (@(posedge clock) disable iff (reset)
      cmd.done |-> ##2 rsp_strobe && rsp_status == STATUS_OK)
      else $error("build finished without result word");

   a_query_word: assert property (@(posedge clock) disable iff (reset)
      cmd.query |=> q1_vld_ff)
      else $error("query dropped");

endmodule
